[rtl/core/frgcd_pkg.sv]
// Shared types for the fraction GCD reduction block.
// No dependencies; imported by frgcd_div and fraction_gcd_reduce_unit.
`timescale 1ns / 1ps
package frgcd_pkg;

  // Status of the shared serial divider, seen by the sequencer
  typedef struct packed {
    logic busy;   // division in progress
    logic done;   // one-cycle pulse: quotient and remainder valid
  } frgcd_div_stat_t;

endpackage

[rtl/core/fraction_gcd_reduce_unit.sv]
// Top level of the fraction GCD reduction block: stream ports and sequencer.
// Depends on frgcd_pkg and frgcd_div.
//
// Usage: present a fraction on the s_ group; a word is taken when s_tvalid and
// s_tready are both high. s_tready is high only while the sequencer is idle,
// so one fraction is worked on at a time. The reduced fraction and the signed
// common divisor appear on the m_ group and hold until m_tready takes them.
// The output register parts the two sides: a new fraction may be accepted
// while the previous result still waits, and the sequencer only stalls at
// the end of the next item if that result has not yet been taken.
// A zero numerator skips the divider and goes through S_DONE to the output
// register. Otherwise every division runs on the shared serial divider at one
// quotient bit per cycle, and an item needs k Euclid remainder steps plus two
// exact divisions, k at most about 46 for 32 bits and far fewer for typical operands.
// Reset (rst, synchronous) drops any item in flight and clears m_tvalid.
`timescale 1ns / 1ps
module fraction_gcd_reduce_unit
  import frgcd_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // fields from bit 0: num_in, den_in, zero pad to whole bytes
  input  logic [8*((2*WORD_BITS+7)/8)-1:0]      s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // fields from bit 0: num_out, den_out, common_divisor, zero pad to whole bytes
  output logic [8*((3*WORD_BITS+7)/8)-1:0]      m_tdata
);

  localparam int OUT_W = 8 * ((3 * WORD_BITS + 7) / 8);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REM,    // Euclid remainder steps
    S_QNUM,   // numerator divided by the common divisor
    S_QDEN,   // denominator divided by the common divisor
    S_DONE    // wait for the output register to free up
  } state_t;

  state_t               state;
  logic [WORD_BITS-1:0] num_r;
  logic [WORD_BITS-1:0] den_r;
  logic [WORD_BITS-1:0] n;        // current Euclid divisor
  logic [WORD_BITS-1:0] res_num;
  logic [WORD_BITS-1:0] res_den;
  logic [WORD_BITS-1:0] res_div;
  logic [WORD_BITS-1:0] op_a;
  logic [WORD_BITS-1:0] op_b;
  logic                 go;

  frgcd_div_stat_t      stat;
  logic [WORD_BITS-1:0] quo;
  logic [WORD_BITS-1:0] rem;

  logic [WORD_BITS-1:0] in_num;
  logic [WORD_BITS-1:0] in_den;

  assign in_num   = s_tdata[WORD_BITS-1:0];
  assign in_den   = s_tdata[2*WORD_BITS-1:WORD_BITS];
  assign s_tready = (state == S_IDLE);

  frgcd_div #(
    .WORD_BITS(WORD_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .op_a (op_a),
    .op_b (op_b),
    .stat (stat),
    .quo  (quo),
    .rem  (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      go       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      go <= 1'b0;
      // drop the output word once taken, unless a new one replaces it
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            num_r <= in_num;
            den_r <= in_den;
            if (in_num == '0) begin
              // zero numerator passes through with divisor 1
              res_num <= '0;
              res_den <= in_den;
              res_div <= {{(WORD_BITS-1){1'b0}}, 1'b1};
              state   <= S_DONE;
            end else begin
              n     <= in_num;
              op_a  <= in_den;
              op_b  <= in_num;
              go    <= 1'b1;
              state <= S_REM;
            end
          end
        end
        S_REM: begin
          if (stat.done) begin
            if (rem == '0) begin
              // n is the signed common divisor
              res_div <= n;
              op_a    <= num_r;
              op_b    <= n;
              go      <= 1'b1;
              state   <= S_QNUM;
            end else begin
              // advance the pair to (n, m rem n)
              n    <= rem;
              op_a <= n;
              op_b <= rem;
              go   <= 1'b1;
            end
          end
        end
        S_QNUM: begin
          if (stat.done) begin
            res_num <= quo;
            op_a    <= den_r;
            op_b    <= res_div;
            go      <= 1'b1;
            state   <= S_QDEN;
          end
        end
        S_QDEN: begin
          if (stat.done) begin
            res_den <= quo;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is empty or being emptied
          if (!m_tvalid || m_tready) begin
            m_tdata  <= OUT_W'({res_div, res_den, res_num});
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // never launch a division on top of one in progress
  a_go_not_busy: assert property (@(posedge clk) disable iff (rst)
    go |-> !stat.busy)
    else $error("divider launched while busy");

  // the divider is quiet whenever the sequencer accepts input
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!stat.busy && !go))
    else $error("divider active while idle");

  // a delivered common divisor is never zero
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3*WORD_BITS-1:2*WORD_BITS] != '0))
    else $error("zero common divisor on output");
`endif

endmodule

[rtl/core/frgcd_div.sv]
// Radix-2 restoring signed divider, one quotient bit per cycle.
// Gives truncated quotient and remainder; depends on frgcd_pkg.
`timescale 1ns / 1ps
module frgcd_div
  import frgcd_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [WORD_BITS-1:0]        op_a,
  input  logic [WORD_BITS-1:0]        op_b,
  output frgcd_div_stat_t             stat,
  output logic [WORD_BITS-1:0]        quo,
  output logic [WORD_BITS-1:0]        rem
);

  localparam int CNT_W = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] dvd;   // dividend bits shifting out, quotient bits shifting in
  logic [WORD_BITS-1:0] dvs;
  logic [WORD_BITS-1:0] part;  // partial remainder, below dvs whenever dvs is nonzero
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic                 done;
  logic                 neg_q;
  logic                 neg_r;

  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS+1:0] diff;

  assign trial = {part, dvd[WORD_BITS-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        // take magnitudes; the most negative value maps to its unsigned magnitude
        dvd   <= op_a[WORD_BITS-1] ? ({WORD_BITS{1'b0}} - op_a) : op_a;
        dvs   <= op_b[WORD_BITS-1] ? ({WORD_BITS{1'b0}} - op_b) : op_b;
        part  <= '0;
        neg_q <= op_a[WORD_BITS-1] ^ op_b[WORD_BITS-1];
        neg_r <= op_a[WORD_BITS-1];
        cnt   <= CNT_W'(WORD_BITS);
        busy  <= 1'b1;
      end else if (busy) begin
        if (!diff[WORD_BITS+1]) begin
          part <= diff[WORD_BITS-1:0];
        end else begin
          part <= trial[WORD_BITS-1:0];
        end
        dvd <= {dvd[WORD_BITS-2:0], ~diff[WORD_BITS+1]};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder follows the dividend sign; quotient wraps on overflow
  assign quo = neg_q ? ({WORD_BITS{1'b0}} - dvd) : dvd;
  assign rem = neg_r ? ({WORD_BITS{1'b0}} - part) : part;

  assign stat.busy = busy;
  assign stat.done = done;

endmodule
